// File: rtl/sist_pkg.sv
// ----------------------------------------------------------------------------
// sist_pkg
// Shared types, constants and helpers for the strided index shuffle table.
// ----------------------------------------------------------------------------
package sist_pkg;

  localparam int MAX_PAGES_DEF  = 16384;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam logic [63:0] LCG_MUL   = 64'd6364136223846793005;
  localparam logic [63:0] LCG_ADD   = 64'd1442695040888963407;
  localparam logic [63:0] SEED_BASE = 64'h5eedead;
  localparam logic [63:0] SEED_STEP = 64'h10001;

  // register indexes on the configuration port
  localparam logic [1:0] REG_FAMILY  = 2'd0;
  localparam logic [1:0] REG_SHUFFLE = 2'd1;
  localparam logic [1:0] REG_PAGES   = 2'd2;

  // request codes
  localparam logic REQ_BUILD = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [13:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [25:0] offset;
    logic [14:0] entry_count;
    logic        valid_res;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_MUL,
    ST_MOD,
    ST_RDA,
    ST_RDB,
    ST_WRA,
    ST_WRB,
    ST_DONE
  } state_t;

  // base offset within the page per family; six and seven wrap to zero and one
  function automatic logic [10:0] base_of(input logic [2:0] fam);
    logic [10:0] b;
    case (fam)
      3'd0, 3'd6: b = 11'd0;
      3'd1, 3'd7: b = 11'd64;
      3'd2:       b = 11'd128;
      3'd3:       b = 11'd256;
      3'd4:       b = 11'd512;
      3'd5:       b = 11'd1024;
      default:    b = 11'd0;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/sist_req_if.sv
// ----------------------------------------------------------------------------
// sist_req_if
// Request channel: valid/ready handshake carrying one request beat.
// ----------------------------------------------------------------------------
interface sist_req_if;
  import sist_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sist_res_if.sv
// ----------------------------------------------------------------------------
// sist_res_if
// Result channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface sist_res_if;
  import sist_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/strided_index_shuffle_table.sv
// ----------------------------------------------------------------------------
// strided_index_shuffle_table
// Page offset table with an optional LCG-driven Fisher-Yates shuffle.
//
// A request beat on req is either a build or a read. Each request gives
// exactly one result beat on res. Registers (family, shuffle_enable,
// buf_pages) on the cfg port are to be written only while the block is
// idle; the block itself does not enforce it. A read registers the table
// word on acceptance, then, once the output register is free, scales the
// page by PAGE_BYTES, adds the family base and loads the output register.
// A new read is accepted only after the last one is done. A build fills
// n = min(buf_pages, MAX_PAGES) entries one per cycle, then, with shuffle
// on, runs n-1 swaps, each an LCG step on one shared 32x32 multiplier,
// a bit-serial modulo, then two reads and two writes on a single port pair.
// One request is in flight at a time; req.ready is high only when idle.
// A result waiting on res does not block acceptance of the next request,
// but that request finishes only once the output register is free.
// Reset clears control state and the stored count; table contents are
// undefined until the first build, and reads before it return invalid.
// ----------------------------------------------------------------------------
module strided_index_shuffle_table #(
  parameter int MAX_PAGES  = sist_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = sist_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  sist_req_if.sink    req,
  sist_res_if.source  res
);
  import sist_pkg::*;

  localparam int AW  = $clog2(MAX_PAGES);
  localparam int CW  = $clog2(MAX_PAGES + 1);
  localparam int PBW = $clog2(PAGE_BYTES + 1);
  localparam int OW  = AW + PBW + 1;

  // configuration registers
  logic [2:0]  family;
  logic        shuffle_enable;
  logic [14:0] buf_pages;

  always_ff @(posedge clk) begin
    if (rst) begin
      family         <= 3'd0;
      shuffle_enable <= 1'b0;
      buf_pages      <= 15'd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FAMILY:  family         <= cfg_data[2:0];
        REG_SHUFFLE: shuffle_enable <= cfg_data[0];
        REG_PAGES:   buf_pages      <= cfg_data;
        default: ;
      endcase
    end
  end

  // table memory
  logic [AW-1:0] mem [MAX_PAGES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  // control and datapath state
  state_t        state, state_next;
  logic [CW-1:0] stored_count;
  logic [10:0]   built_base;
  logic          do_shuffle;
  logic [CW-1:0] cnt;        // fill index, then shuffle bound i
  logic [63:0]   rng;
  logic [63:0]   acc;
  logic [1:0]    mstep;
  logic [63:0]   dividend;
  logic [5:0]    mbit;
  logic [CW-1:0] rem;
  logic [AW-1:0] swap_j;
  logic [AW-1:0] hold;
  logic          rd_ok;
  logic          out_free;
  logic          acc_in;

  logic [CW-1:0] build_n;
  logic [CW:0]   trial;
  logic [CW:0]   trial_sub;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod;
  logic [OW-1:0] off_full;

  assign out_free = !res.valid || res.ready;
  assign acc_in   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  assign build_n = (32'(buf_pages) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(buf_pages);

  // shared multiplier for the lcg step
  assign mul_a = (mstep == 2'd1) ? rng[63:32] : rng[31:0];
  assign mul_b = (mstep == 2'd2) ? LCG_MUL[63:32] : LCG_MUL[31:0];
  assign prod  = mul_a * mul_b;

  // restoring modulo step
  assign trial     = {rem, dividend[63]};
  assign trial_sub = trial - {1'b0, cnt};

  // page scaled to a byte offset
  assign off_full = OW'(mem_rdata) * OW'(PAGE_BYTES) + OW'(built_base);

  // next state and memory controls
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = AW'(cnt);
    mem_wdata  = AW'(cnt);
    mem_re     = 1'b0;
    mem_raddr  = req.data.entry_index[AW-1:0];
    case (state)
      ST_IDLE: begin
        if (acc_in) begin
          if (req.data.req_type == REQ_READ) begin
            mem_re     = 1'b1;
            state_next = ST_READ;
          end else if (build_n == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_FILL;
          end
        end
      end
      ST_READ: if (out_free) state_next = ST_IDLE;
      ST_FILL: begin
        mem_we = 1'b1;
        if (cnt + CW'(1) == stored_count) begin
          state_next = (do_shuffle && stored_count >= CW'(2)) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: if (mstep == 2'd3) state_next = ST_MOD;
      ST_MOD: if (mbit == 6'd0) state_next = ST_RDA;
      ST_RDA: begin
        mem_re     = 1'b1;
        mem_raddr  = AW'(cnt - CW'(1));
        state_next = ST_RDB;
      end
      ST_RDB: begin
        mem_re     = 1'b1;
        mem_raddr  = swap_j;
        state_next = ST_WRA;
      end
      ST_WRA: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(cnt - CW'(1));
        mem_wdata  = mem_rdata;
        state_next = ST_WRB;
      end
      ST_WRB: begin
        mem_we     = 1'b1;
        mem_waddr  = swap_j;
        mem_wdata  = hold;
        state_next = (cnt == CW'(2)) ? ST_DONE : ST_MUL;
      end
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      built_base   <= 11'd0;
      res.valid    <= 1'b0;
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      if (state == ST_IDLE && acc_in && req.data.req_type == REQ_BUILD) begin
        stored_count <= build_n;
        built_base   <= base_of(family);
      end
      if ((state == ST_READ || state == ST_DONE) && out_free) res.valid <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rd_ok      <= (32'(req.data.entry_index) < 32'(stored_count));
        do_shuffle <= shuffle_enable;
        rng        <= SEED_BASE + 64'(family) * SEED_STEP;
        cnt        <= '0;
        mstep      <= 2'd0;
      end
      ST_FILL: begin
        if (cnt + CW'(1) == stored_count) cnt <= stored_count;
        else                              cnt <= cnt + CW'(1);
      end
      ST_MUL: begin
        case (mstep)
          2'd0:    acc <= prod;
          2'd1:    acc[63:32] <= acc[63:32] + prod[31:0];
          2'd2:    acc[63:32] <= acc[63:32] + prod[31:0];
          default: begin
            rng      <= acc + LCG_ADD;
            dividend <= acc + LCG_ADD;
            rem      <= '0;
            mbit     <= 6'd63;
          end
        endcase
        mstep <= mstep + 2'd1;
      end
      ST_MOD: begin
        if (!trial_sub[CW]) rem <= trial_sub[CW-1:0];
        else                rem <= trial[CW-1:0];
        dividend <= {dividend[62:0], 1'b0};
        mbit     <= mbit - 6'd1;
      end
      ST_RDA: swap_j <= AW'(rem);
      ST_RDB: hold <= mem_rdata;
      ST_WRB: begin
        cnt   <= cnt - CW'(1);
        mstep <= 2'd0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_READ && out_free) begin
      res.data.offset      <= rd_ok ? off_full[25:0] : 26'd0;
      res.data.entry_count <= 15'(stored_count);
      res.data.valid_res   <= rd_ok;
    end else if (state == ST_DONE && out_free) begin
      res.data.offset      <= 26'd0;
      res.data.entry_count <= 15'(stored_count);
      res.data.valid_res   <= 1'b1;
    end
  end

endmodule
